// ===== rtl/core/cts_pkg.sv =====
// Shared types and codes for the cooperative task scheduler table.
// Holds command and status codes, field widths and the slot update flags.
// No dependencies; the interfaces, the slot update unit, the table and the testbench use it.
package cts_pkg;

    localparam int CMD_W    = 2;
    localparam int FIELD_W  = 16;
    localparam int IDX_W    = 5;
    localparam int STATUS_W = 2;
    localparam int RUNS_W   = 8;

    localparam logic [RUNS_W-1:0] RUNS_MAX = {RUNS_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD  = 2'd0,
        CMD_DEL  = 2'd1,
        CMD_TICK = 2'd2,
        CMD_DISP = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Decisions of the slot update unit for the slot now being walked.
    typedef struct packed {
        logic wr;        // write the updated entry back
        logic due;       // dispatch: slot has runs due
        logic one_shot;  // dispatch: slot is freed after this run
    } t_upd_flags;

endpackage

// ===== rtl/core/cts_if.sv =====
// Handshake interfaces for the command and result channels of the scheduler table.
// Depends on cts_pkg for the field widths.
interface cts_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [cts_pkg::CMD_W-1:0]    command;
    logic [cts_pkg::FIELD_W-1:0]  task_handle;
    logic [cts_pkg::FIELD_W-1:0]  first_delay;
    logic [cts_pkg::FIELD_W-1:0]  repeat_period;
    logic [cts_pkg::IDX_W-1:0]    slot_index;

    modport source (output valid, command, task_handle, first_delay, repeat_period,
                    slot_index, input ready);
    modport sink (input valid, command, task_handle, first_delay, repeat_period,
                  slot_index, output ready);
endinterface

interface cts_res_if;
    logic                          valid;
    logic                          ready;
    logic [cts_pkg::STATUS_W-1:0]  status;
    logic [cts_pkg::IDX_W-1:0]     slot_out;
    logic [cts_pkg::FIELD_W-1:0]   run_handle;
    logic                          run_valid;
    logic                          last;

    modport source (output valid, status, slot_out, run_handle, run_valid, last,
                    input ready);
    modport sink (input valid, status, slot_out, run_handle, run_valid, last,
                  output ready);
endinterface

// ===== rtl/core/cts_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/cts_slot_upd.sv =====
// Slot update unit: computes the new delay and run count of one slot for a tick
// or a dispatch, and whether the entry is due, freed or written back. Uses cts_pkg.
module cts_slot_upd #(
    parameter int TICK_BITS = 16
) (
    input  logic                          i_tick,
    input  logic                          i_used,
    input  logic [TICK_BITS-1:0]          i_delay,
    input  logic [TICK_BITS-1:0]          i_period,
    input  logic [cts_pkg::RUNS_W-1:0]    i_runs,
    output logic [TICK_BITS-1:0]          o_delay,
    output logic [cts_pkg::RUNS_W-1:0]    o_runs,
    output cts_pkg::t_upd_flags           o_flags
);

    logic runs_nz;
    logic period_nz;

    assign runs_nz   = (i_runs != '0);
    assign period_nz = (i_period != '0);

    always_comb begin
        o_delay  = i_delay;
        o_runs   = i_runs;
        o_flags  = '0;
        if (i_tick) begin
            // Aging: a slot at zero delay earns a run and reloads when periodic.
            o_flags.wr = i_used;
            if (i_delay == '0) begin
                if (i_runs != cts_pkg::RUNS_MAX) begin
                    o_runs = i_runs + cts_pkg::RUNS_W'(1);
                end
                if (period_nz) begin
                    o_delay = i_period;
                end
            end else begin
                o_delay = i_delay - TICK_BITS'(1);
            end
        end else begin
            o_flags.due      = i_used & runs_nz;
            o_flags.wr       = i_used & runs_nz;
            o_flags.one_shot = ~period_nz;
            o_runs           = i_runs - cts_pkg::RUNS_W'(1);
        end
    end

endmodule

// ===== rtl/core/cooperative_task_scheduler_table.sv =====
// Time-triggered cooperative scheduler table.
// A command transaction on i_cmd carries add, delete, tick or dispatch. Add, delete and
// tick answer with one result transaction on o_res; dispatch answers with one result per
// slot that has runs due, in slot order, or with one empty result when none is due. The
// final result of every command has last set.
// Delete goes straight to S_DONE. Add first scans the used bits from slot 0 up to the lowest
// free slot, or to the last slot when the table is full; tick and dispatch walk every slot
// in S_WALK. Dispatch holds each due slot in the staged result and offers it once the next
// due slot is found or in S_DONE. The walk reads one entry and writes at most one back per
// cycle, unless a stalled output register halts a dispatch walk on a due slot.
// A new command is taken only once the previous one has queued its final result, but it
// is taken while that result still waits in the output register.
// Reset clears all used bits, so the table comes up empty; the slot memory itself is not
// cleared, since an entry's fields are only acted on after add has written it.
// When the receiver stalls, results stay in the output register, and a dispatch walk
// halts on the next due slot until the register frees up.
// Depends on cts_pkg, cts_if, cts_ram and cts_slot_upd.
module cooperative_task_scheduler_table #(
    parameter int SLOTS       = 32,
    parameter int TICK_BITS   = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cts_cmd_if.sink    i_cmd,
    cts_res_if.source  o_res
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RUNS_W = cts_pkg::RUNS_W;
    localparam int WORD_W = HANDLE_BITS + 2 * TICK_BITS + RUNS_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_ADD_SCAN = 4'b0010,
        S_WALK     = 4'b0100,
        S_DONE     = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_is_tick, n_is_tick;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic [SLOTS-1:0]  r_used, n_used;

    logic [HANDLE_BITS-1:0] r_add_handle, n_add_handle;
    logic [TICK_BITS-1:0]   r_add_delay, n_add_delay;
    logic [TICK_BITS-1:0]   r_add_period, n_add_period;

    // Staged result: the pending dispatch entry, or the single answer of other commands.
    logic                             r_pend_valid, n_pend_valid;
    logic [cts_pkg::STATUS_W-1:0]     r_pend_status, n_pend_status;
    logic [cts_pkg::IDX_W-1:0]        r_pend_slot, n_pend_slot;
    logic [cts_pkg::FIELD_W-1:0]      r_pend_handle, n_pend_handle;
    logic                             r_pend_run, n_pend_run;

    // Output register.
    logic                             r_out_valid, n_out_valid;
    logic [cts_pkg::STATUS_W-1:0]     r_out_status;
    logic [cts_pkg::IDX_W-1:0]        r_out_slot;
    logic [cts_pkg::FIELD_W-1:0]      r_out_handle;
    logic                             r_out_run;
    logic                             r_out_last;
    logic                             out_load;
    logic                             out_last;
    logic                             out_free;

    logic                             in_acc;
    logic                             idx_in_range;
    logic                             cur_used;
    logic                             proceed;

    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic [SLOT_W-1:0] mem_raddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] mem_rdata;

    logic [HANDLE_BITS-1:0] rd_handle;
    logic [TICK_BITS-1:0]   rd_delay;
    logic [TICK_BITS-1:0]   rd_period;
    logic [RUNS_W-1:0]      rd_runs;
    logic [TICK_BITS-1:0]   upd_delay;
    logic [RUNS_W-1:0]      upd_runs;
    cts_pkg::t_upd_flags    upd_flags;

    // Slot entry layout: {handle, delay, period, runs}.
    assign rd_handle = mem_rdata[WORD_W-1 -: HANDLE_BITS];
    assign rd_delay  = mem_rdata[RUNS_W + TICK_BITS +: TICK_BITS];
    assign rd_period = mem_rdata[RUNS_W +: TICK_BITS];
    assign rd_runs   = mem_rdata[RUNS_W-1:0];

    cts_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign cur_used = r_used[r_idx];

    cts_slot_upd #(
        .TICK_BITS (TICK_BITS)
    ) u_slot_upd (
        .i_tick   (r_is_tick),
        .i_used   (cur_used),
        .i_delay  (rd_delay),
        .i_period (rd_period),
        .i_runs   (rd_runs),
        .o_delay  (upd_delay),
        .o_runs   (upd_runs),
        .o_flags  (upd_flags)
    );

    assign i_cmd.ready  = (r_state == S_IDLE);
    assign in_acc       = i_cmd.valid & i_cmd.ready;
    assign out_free     = ~r_out_valid | o_res.ready;
    assign idx_in_range = (32'(i_cmd.slot_index) < SLOTS);

    always_comb begin
        n_state       = r_state;
        n_is_tick     = r_is_tick;
        n_idx         = r_idx;
        n_used        = r_used;
        n_add_handle  = r_add_handle;
        n_add_delay   = r_add_delay;
        n_add_period  = r_add_period;
        n_pend_valid  = r_pend_valid;
        n_pend_status = r_pend_status;
        n_pend_slot   = r_pend_slot;
        n_pend_handle = r_pend_handle;
        n_pend_run    = r_pend_run;
        mem_we        = 1'b0;
        mem_waddr     = r_idx;
        mem_raddr     = '0;
        mem_wdata     = {rd_handle, upd_delay, rd_period, upd_runs};
        out_load      = 1'b0;
        out_last      = 1'b0;
        proceed       = 1'b0;

        case (r_state)
            S_IDLE: begin
                // The read of slot 0 is issued here so a walk starts with its data.
                if (in_acc) begin
                    n_idx         = '0;
                    n_pend_valid  = 1'b0;
                    n_pend_status = cts_pkg::ST_OK;
                    n_pend_slot   = '0;
                    n_pend_handle = '0;
                    n_pend_run    = 1'b0;
                    case (i_cmd.command)
                        cts_pkg::CMD_ADD: begin
                            n_add_handle = HANDLE_BITS'(i_cmd.task_handle);
                            n_add_delay  = TICK_BITS'(i_cmd.first_delay);
                            n_add_period = TICK_BITS'(i_cmd.repeat_period);
                            n_state      = S_ADD_SCAN;
                        end
                        cts_pkg::CMD_DEL: begin
                            n_pend_slot   = i_cmd.slot_index;
                            n_pend_status = cts_pkg::ST_EMPTY;
                            if (idx_in_range) begin
                                if (r_used[SLOT_W'(i_cmd.slot_index)]) begin
                                    n_pend_status = cts_pkg::ST_OK;
                                end
                                n_used[SLOT_W'(i_cmd.slot_index)] = 1'b0;
                            end
                            n_state = S_DONE;
                        end
                        cts_pkg::CMD_TICK: begin
                            n_is_tick = 1'b1;
                            n_state   = S_WALK;
                        end
                        default: begin
                            n_is_tick = 1'b0;
                            n_state   = S_WALK;
                        end
                    endcase
                end
            end

            S_ADD_SCAN: begin
                // Lowest free slot, checked one used bit per cycle.
                if (!cur_used) begin
                    mem_we        = 1'b1;
                    mem_wdata     = {r_add_handle, r_add_delay, r_add_period, RUNS_W'(0)};
                    n_used[r_idx] = 1'b1;
                    n_pend_slot   = cts_pkg::IDX_W'(r_idx);
                    n_state       = S_DONE;
                end else if (r_idx == LAST_SLOT) begin
                    n_pend_status = cts_pkg::ST_FULL;
                    n_state       = S_DONE;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end

            S_WALK: begin
                // A due slot while an earlier one is still pending needs the output
                // register; otherwise the walk moves on every cycle.
                proceed = ~(~r_is_tick & upd_flags.due & r_pend_valid & ~out_free);
                if (proceed && r_idx != LAST_SLOT) begin
                    mem_raddr = r_idx + SLOT_W'(1);
                end else begin
                    mem_raddr = r_idx;
                end
                if (proceed) begin
                    mem_we = upd_flags.wr;
                    if (!r_is_tick && upd_flags.due) begin
                        if (r_pend_valid) begin
                            out_load = 1'b1;
                        end
                        n_pend_valid  = 1'b1;
                        n_pend_slot   = cts_pkg::IDX_W'(r_idx);
                        n_pend_handle = cts_pkg::FIELD_W'(rd_handle);
                        n_pend_run    = 1'b1;
                        if (upd_flags.one_shot) begin
                            n_used[r_idx] = 1'b0;
                        end
                    end
                    if (r_idx == LAST_SLOT) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx = r_idx + SLOT_W'(1);
                    end
                end
            end

            S_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_last = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_is_tick    <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_state      <= n_state;
            r_used       <= n_used;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_is_tick    <= n_is_tick;
            r_idx        <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_add_handle  <= n_add_handle;
        r_add_delay   <= n_add_delay;
        r_add_period  <= n_add_period;
        r_pend_status <= n_pend_status;
        r_pend_slot   <= n_pend_slot;
        r_pend_handle <= n_pend_handle;
        r_pend_run    <= n_pend_run;
        if (out_load) begin
            r_out_status <= r_pend_status;
            r_out_slot   <= r_pend_slot;
            r_out_handle <= r_pend_handle;
            r_out_run    <= r_pend_run;
            r_out_last   <= out_last;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_out_status;
    assign o_res.slot_out   = r_out_slot;
    assign o_res.run_handle = r_out_handle;
    assign o_res.run_valid  = r_out_run;
    assign o_res.last       = r_out_last;

    // The walk never reads the entry it writes back, except at the final slot.
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state == S_WALK && r_idx != LAST_SLOT) |-> (mem_raddr != mem_waddr))
        else $error("slot memory read and write collide during walk");

    // A result that names a task always reports success.
    a_run_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_run) |-> (r_out_status == cts_pkg::ST_OK))
        else $error("dispatched task carries an error status");

    // An accepted command always takes the sequencer out of the idle state.
    a_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("command accepted without being processed");

    // A stalled dispatch walk keeps its place and its pending entry.
    a_walk_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && !proceed) |=> (r_state == S_WALK && r_pend_valid
            && r_idx == $past(r_idx)))
        else $error("dispatch walk moved while stalled");

endmodule

// ===== test/tb_cooperative_task_scheduler_table.sv =====
// Self-checking testbench for the cooperative task scheduler table.
// Drives add, delete, tick and dispatch commands and predicts every result transaction.
// Depends on cts_pkg, cts_if and cooperative_task_scheduler_table from the RTL.
module tb_cooperative_task_scheduler_table;

    localparam int N_SLOTS     = 32;
    localparam int CYCLE_LIMIT = 200000;

    // One command as the sender queues it. The drain flag holds the command back until
    // every outstanding result has been received; calm marks the tail of the run, where
    // neither side inserts idle cycles.
    typedef struct {
        cts_pkg::t_cmd              op;
        logic [15:0]                handle;
        logic [15:0]                delay;
        logic [15:0]                period;
        logic [cts_pkg::IDX_W-1:0]  idx;
        bit                         drain;
        bit                         calm;
    } t_sched_cmd;

    typedef struct {
        cts_pkg::t_status           status;
        logic [cts_pkg::IDX_W-1:0]  slot;
        logic [15:0]                handle;
        logic                       run;
        logic                       last;
    } t_sched_reply;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cts_cmd_if cmd_bus ();
    cts_res_if res_bus ();

    cooperative_task_scheduler_table #(
        .SLOTS       (N_SLOTS),
        .TICK_BITS   (16),
        .HANDLE_BITS (16)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the task table, updated as each command transaction is accepted.
    bit          tab_used   [N_SLOTS];
    logic [15:0] tab_handle [N_SLOTS];
    logic [15:0] tab_delay  [N_SLOTS];
    logic [15:0] tab_period [N_SLOTS];
    logic [7:0]  tab_runs   [N_SLOTS];

    t_sched_cmd   cmd_backlog[$];     // commands not yet offered to the block
    t_sched_reply queued_replies[$];  // results owed by the block, oldest first
    t_sched_cmd   on_wire;            // command currently offered on cmd_bus

    bit hold_next = 1'b0;
    bit tail_calm = 1'b0;
    bit quiet     = 1'b0;

    int gap_left   = 0;
    int stall_left = 0;
    int mismatches = 0;
    int n_checked  = 0;
    int n_runs     = 0;
    int n_full     = 0;
    int n_empty    = 0;
    int cycle_count = 0;
    int op_count[4] = '{0, 0, 0, 0};

    function automatic t_sched_reply make_reply(input cts_pkg::t_status st, input int slot,
                                                input logic [15:0] h, input logic run,
                                                input logic last);
        t_sched_reply r;
        r.status = st;
        r.slot   = cts_pkg::IDX_W'(slot);
        r.handle = h;
        r.run    = run;
        r.last   = last;
        return r;
    endfunction

    function automatic void free_slot(input int s);
        tab_used[s]   = 1'b0;
        tab_handle[s] = '0;
        tab_delay[s]  = '0;
        tab_period[s] = '0;
        tab_runs[s]   = '0;
    endfunction

    // Applies one accepted command to the shadow table and queues the results that the
    // block owes for it.
    function automatic void run_scheduler_command(input t_sched_cmd c);
        t_sched_reply burst[$];
        int s;
        case (c.op)
            cts_pkg::CMD_ADD: begin
                // The lowest free slot takes the task; a zero handle is a valid task.
                s = 0;
                while (s < N_SLOTS && tab_used[s]) s++;
                if (s == N_SLOTS) begin
                    queued_replies.push_back(make_reply(cts_pkg::ST_FULL, 0, '0, 1'b0,
                                                        1'b1));
                    n_full++;
                end else begin
                    tab_used[s]   = 1'b1;
                    tab_handle[s] = c.handle;
                    tab_delay[s]  = c.delay;
                    tab_period[s] = c.period;
                    tab_runs[s]   = '0;
                    queued_replies.push_back(make_reply(cts_pkg::ST_OK, s, '0, 1'b0, 1'b1));
                end
            end
            cts_pkg::CMD_DEL: begin
                // An empty slot still reports its index, with the empty status.
                if (!tab_used[c.idx]) n_empty++;
                queued_replies.push_back(make_reply(tab_used[c.idx] ? cts_pkg::ST_OK
                                                                    : cts_pkg::ST_EMPTY,
                                                    int'(c.idx), '0, 1'b0, 1'b1));
                free_slot(int'(c.idx));
            end
            cts_pkg::CMD_TICK: begin
                for (s = 0; s < N_SLOTS; s++) begin
                    if (tab_used[s]) begin
                        if (tab_delay[s] == '0) begin
                            if (tab_runs[s] != cts_pkg::RUNS_MAX) tab_runs[s]++;
                            if (tab_period[s] != '0) tab_delay[s] = tab_period[s];
                        end else begin
                            tab_delay[s] = tab_delay[s] - 16'd1;
                        end
                    end
                end
                queued_replies.push_back(make_reply(cts_pkg::ST_OK, 0, '0, 1'b0, 1'b1));
            end
            default: begin
                // Dispatch: one result per slot with runs due, in slot order. A one-shot
                // task leaves the table after its first dispatch, whatever runs remain.
                for (s = 0; s < N_SLOTS; s++) begin
                    if (tab_runs[s] != '0) begin
                        burst.push_back(make_reply(cts_pkg::ST_OK, s, tab_handle[s], 1'b1,
                                                   1'b0));
                        tab_runs[s]--;
                        if (tab_period[s] == '0) free_slot(s);
                    end
                end
                if (burst.size() == 0) begin
                    burst.push_back(make_reply(cts_pkg::ST_OK, 0, '0, 1'b0, 1'b1));
                end else begin
                    burst[burst.size() - 1].last = 1'b1;
                end
                n_runs += burst.size() - (burst[0].run ? 0 : 1);
                foreach (burst[i]) queued_replies.push_back(burst[i]);
            end
        endcase
    endfunction

    function automatic logic [15:0] rnd16();
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic push_cmd(input cts_pkg::t_cmd op, input logic [15:0] h,
                            input logic [15:0] d, input logic [15:0] p,
                            input logic [cts_pkg::IDX_W-1:0] idx);
        t_sched_cmd c;
        c.op     = op;
        c.handle = h;
        c.delay  = d;
        c.period = p;
        c.idx    = idx;
        c.drain  = hold_next;
        c.calm   = tail_calm;
        hold_next = 1'b0;
        cmd_backlog.push_back(c);
    endtask

    // Fields that a command ignores still carry random values.
    task automatic push_op(input cts_pkg::t_cmd op);
        push_cmd(op, rnd16(), rnd16(), rnd16(), cts_pkg::IDX_W'($urandom_range(0, 31)));
    endtask

    task automatic push_add(input logic [15:0] h, input logic [15:0] d,
                            input logic [15:0] p);
        push_cmd(cts_pkg::CMD_ADD, h, d, p, cts_pkg::IDX_W'($urandom_range(0, 31)));
    endtask

    task automatic push_del(input int idx);
        push_cmd(cts_pkg::CMD_DEL, rnd16(), rnd16(), rnd16(), cts_pkg::IDX_W'(idx));
    endtask

    // Short delays and periods keep tasks firing; now and then a full-range value
    // exercises the upper bits of the tick counters.
    task automatic push_random_add();
        logic [15:0] h;
        logic [15:0] d;
        logic [15:0] p;
        h = ($urandom_range(0, 15) == 0) ? 16'h0000 : rnd16();
        d = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 4)) : rnd16();
        case ($urandom_range(0, 5))
            0, 1:    p = 16'h0000;
            5:       p = rnd16();
            default: p = 16'($urandom_range(1, 4));
        endcase
        push_add(h, d, p);
    endtask

    // A typical usage pattern: add a few tasks, let time pass, dispatch and retire some
    // slots. Occasionally a run of arbitrary commands follows as noise.
    task automatic push_episode();
        repeat ($urandom_range(1, 4)) push_random_add();
        repeat ($urandom_range(1, 6)) push_op(cts_pkg::CMD_TICK);
        push_op(cts_pkg::CMD_DISP);
        if ($urandom_range(0, 1) == 0) push_op(cts_pkg::CMD_DISP);
        repeat ($urandom_range(0, 3)) begin
            push_del(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                 : $urandom_range(0, 11));
        end
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                push_cmd(cts_pkg::t_cmd'($urandom_range(0, 3)), rnd16(), rnd16(), rnd16(),
                         cts_pkg::IDX_W'($urandom_range(0, 31)));
            end
        end
    endtask

    // Command driver. The accepted command is applied to the shadow table at the edge
    // where valid and ready are both high. The next command, if any, is loaded in the
    // same step, so valid gets a single assignment per edge.
    always @(posedge i_clk) begin
        bit offer;
        offer = cmd_bus.valid;
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
        end else begin
            if (cmd_bus.valid && cmd_bus.ready) begin
                run_scheduler_command(on_wire);
                op_count[on_wire.op]++;
                offer = 1'b0;
            end
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmd_backlog.size() != 0 &&
                             !(cmd_backlog[0].drain && queued_replies.size() != 0)) begin
                    if (!cmd_backlog[0].calm && $urandom_range(0, 5) == 0) begin
                        // This cycle opens an idle burst; gap_left holds the idle cycles that remain after it.
                        gap_left = $urandom_range(0, 7);
                    end else begin
                        on_wire = cmd_backlog.pop_front();
                        if (on_wire.calm) quiet = 1'b1;
                        offer = 1'b1;
                        cmd_bus.command       <= on_wire.op;
                        cmd_bus.task_handle   <= on_wire.handle;
                        cmd_bus.first_delay   <= on_wire.delay;
                        cmd_bus.repeat_period <= on_wire.period;
                        cmd_bus.slot_index    <= on_wire.idx;
                    end
                end
            end
            cmd_bus.valid <= offer;
        end
    end

    // Result monitor. Each accepted result transaction is compared with the oldest
    // owed result. Ready drops in random bursts until the tail of the run.
    always @(posedge i_clk) begin
        t_sched_reply want;
        bit take;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                if (queued_replies.size() == 0) begin
                    $error("unexpected result: status %0d slot %0d handle %h",
                           res_bus.status, res_bus.slot_out, res_bus.run_handle);
                    mismatches++;
                end else begin
                    want = queued_replies.pop_front();
                    n_checked++;
                    if (res_bus.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, res_bus.status);
                        mismatches++;
                    end
                    if (res_bus.slot_out !== want.slot) begin
                        $error("slot_out: expected %0d, got %0d", want.slot, res_bus.slot_out);
                        mismatches++;
                    end
                    if (res_bus.run_handle !== want.handle) begin
                        $error("run_handle: expected %h, got %h", want.handle,
                               res_bus.run_handle);
                        mismatches++;
                    end
                    if (res_bus.run_valid !== want.run) begin
                        $error("run_valid: expected %b, got %b", want.run, res_bus.run_valid);
                        mismatches++;
                    end
                    if (res_bus.last !== want.last) begin
                        $error("last: expected %b, got %b", want.last, res_bus.last);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                take = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 7);
                take = 1'b0;
            end else begin
                take = 1'b1;
            end
            res_bus.ready <= take;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("timeout with %0d commands queued and %0d results owed",
                   cmd_backlog.size(), queued_replies.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        i_rst_n               = 1'b0;
        cmd_bus.valid         = 1'b0;
        cmd_bus.command       = cts_pkg::CMD_TICK;
        cmd_bus.task_handle   = '0;
        cmd_bus.first_delay   = '0;
        cmd_bus.repeat_period = '0;
        cmd_bus.slot_index    = '0;
        res_bus.ready         = 1'b0;
        for (int s = 0; s < N_SLOTS; s++) free_slot(s);

        // Directed opening: empty table, extreme field values, zero handle, one-shot and
        // periodic tasks, a dispatch that frees a one-shot task with runs still due,
        // and deletes of both used and empty slots.
        push_op(cts_pkg::CMD_DISP);
        push_op(cts_pkg::CMD_TICK);
        push_del(0);
        push_del(31);
        push_add(16'h0000, 16'h0000, 16'h0000);
        push_add(16'hFFFF, 16'h0000, 16'h0001);
        push_add(16'h8000, 16'hFFFF, 16'hFFFF);
        push_add(16'h7FFF, 16'h0001, 16'h0000);
        push_op(cts_pkg::CMD_TICK);
        push_op(cts_pkg::CMD_TICK);
        hold_next = 1'b1;
        push_op(cts_pkg::CMD_DISP);
        push_op(cts_pkg::CMD_DISP);
        push_del(2);
        push_del(2);
        push_add(16'h5A5A, 16'h0000, 16'h0002);
        push_op(cts_pkg::CMD_TICK);
        push_op(cts_pkg::CMD_DISP);
        push_del(1);
        push_del(0);

        while (cmd_backlog.size() < 50) push_episode();

        // Clear the table, then overfill it so that adds report a full table. With every
        // delay at zero, one tick makes all slots due and the dispatch answers 32 times.
        hold_next = 1'b1;
        for (int s = 0; s < N_SLOTS; s++) push_del(s);
        repeat (N_SLOTS + 2) push_add(rnd16(), 16'h0000, 16'($urandom_range(0, 3)));
        push_op(cts_pkg::CMD_TICK);
        push_op(cts_pkg::CMD_DISP);
        push_del(0);
        push_del(1);

        while (cmd_backlog.size() < 150) push_episode();
        tail_calm = 1'b1;
        repeat (3) push_episode();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || cmd_bus.valid || queued_replies.size() != 0)
            @(posedge i_clk);
        // Any result still on its way would be flagged by the monitor in this window.
        repeat (3 * N_SLOTS) @(posedge i_clk);

        $display("Accepted %0d adds (%0d on a full table), %0d deletes (%0d of empty slots),",
                 op_count[cts_pkg::CMD_ADD], n_full, op_count[cts_pkg::CMD_DEL], n_empty);
        $display("%0d ticks and %0d dispatches; checked %0d results, %0d of them task runs.",
                 op_count[cts_pkg::CMD_TICK], op_count[cts_pkg::CMD_DISP], n_checked, n_runs);
        if (mismatches == 0 && queued_replies.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/cts_pkg.sv
rtl/core/cts_if.sv
rtl/core/cts_ram.sv
rtl/core/cts_slot_upd.sv
rtl/core/cooperative_task_scheduler_table.sv
test/tb_cooperative_task_scheduler_table.sv
